// File: rtl/three_slot_time_alarm_table_assert.svh
// Assertion macros used by the checker of the alarm table.
// Both macros sample on the rising clock edge and are silent during reset.
`ifndef THREE_SLOT_TIME_ALARM_TABLE_ASSERT_SVH
`define THREE_SLOT_TIME_ALARM_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alarm table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alarm table assertion failed");

`endif

// File: rtl/tsat_pkg.sv
package tsat_pkg;

    localparam logic [6:0] MAX_HOURS      = 7'd24;
    localparam logic [6:0] MAX_MINSEC     = 7'd59;
    localparam logic [7:0] BCD_DIGIT_MASK = 8'b00001111;
    localparam logic [7:0] DEC_BASE       = 8'd10;

    typedef enum logic {
        KIND_SET   = 1'b0,
        KIND_CHECK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        RES_SET     = 2'd0,
        RES_FIRED   = 2'd1,
        RES_SUMMARY = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2
    } t_set_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SET,
        S_CHECK,
        S_SUM
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] alarm_hours;
        logic [6:0] alarm_minutes;
        logic [6:0] alarm_seconds;
        logic [7:0] alarm_tag;
        logic [7:0] now_hours_bcd;
        logic [7:0] now_minutes_bcd;
        logic [7:0] now_seconds_bcd;
    } t_in_item;

    typedef struct packed {
        t_result_kind result_kind;
        t_set_status  set_status;
        logic [1:0]   slot_index;
        logic [7:0]   fired_tag;
        logic [1:0]   pending_count;
        logic         keep_running;
        logic         last;
    } t_out_item;

    // Alarm time as kept in a slot.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_slot_time;

    // Time with room for undecodable BCD digits, compared as one word.
    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } t_clock_time;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_slot_ctrl;

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] bcd);
        logic [7:0] ones;
        logic [7:0] tens;
        ones = bcd & BCD_DIGIT_MASK;
        tens = (bcd >> 4) & BCD_DIGIT_MASK;
        return (tens * DEC_BASE) + ones;
    endfunction

endpackage

// File: rtl/tsat_chan_if.sv
interface tsat_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tsat_time_cmp.sv
module tsat_time_cmp (
    input  tsat_pkg::t_clock_time i_lhs,
    input  tsat_pkg::t_clock_time i_rhs,
    output logic                  o_less
);
    import tsat_pkg::*;

    // Hours, minutes and seconds in that order form one word, so a single
    // magnitude compare gives the ordering of the two times.
    assign o_less = (i_lhs < i_rhs);
endmodule

// File: rtl/tsat_slot_table.sv
module tsat_slot_table #(
    parameter int ALARM_SLOTS = 3,
    parameter int TAG_WIDTH   = 8,
    parameter int IDX_W       = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsat_pkg::t_slot_ctrl i_ctrl,
    input  logic [IDX_W-1:0]     i_idx,
    input  tsat_pkg::t_slot_time i_wr_time,
    input  logic [TAG_WIDTH-1:0] i_wr_tag,
    output logic                 o_valid,
    output tsat_pkg::t_slot_time o_time,
    output logic [TAG_WIDTH-1:0] o_tag
);
    import tsat_pkg::*;

    logic [ALARM_SLOTS-1:0] r_valid;
    t_slot_time             r_time [ALARM_SLOTS];
    logic [TAG_WIDTH-1:0]   r_tag  [ALARM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.wr) begin
            r_valid[i_idx] <= 1'b1;
        end else if (i_ctrl.clr) begin
            r_valid[i_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_time[i_idx] <= i_wr_time;
            r_tag[i_idx]  <= i_wr_tag;
        end
    end

    assign o_valid = r_valid[i_idx];
    assign o_time  = r_time[i_idx];
    assign o_tag   = r_tag[i_idx];
endmodule

// File: rtl/three_slot_time_alarm_table.sv
// Alarm table with ALARM_SLOTS slots, worked by one time comparator that steps
// through the slots one per clock cycle while the output register is free. A
// set item is taken and then looks at the slots in turn, up to and including
// the first free one; a time out of range is answered at the first of these
// steps. A check item is taken and its BCD time decoded, then each slot is
// compared in turn, and a summary follows. Results leave through a single
// output register; when it is not emptied, the walk through the slots waits,
// and the block takes the next item once the last result of the current one
// is in that register.
module three_slot_time_alarm_table #(
    parameter int ALARM_SLOTS = 3,
    parameter int TAG_WIDTH   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsat_chan_if.sink   i_item,
    tsat_chan_if.source o_result
);
    import tsat_pkg::*;

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);

    t_in_item             in_data;
    t_state               r_state,    n_state;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic                 r_bad,      n_bad;
    t_slot_time           r_set_time, n_set_time;
    logic [TAG_WIDTH-1:0] r_tag,      n_tag;
    t_clock_time          r_now,      n_now;
    logic [CNT_W-1:0]     r_pending,  n_pending;
    logic                 r_o_valid,  n_o_valid;
    t_out_item            r_o_data,   n_o_data;

    t_slot_ctrl           slot_ctrl;
    logic                 rd_valid;
    t_slot_time           rd_time;
    logic [TAG_WIDTH-1:0] rd_tag;
    t_clock_time          alarm_time;
    logic                 alarm_early;
    logic                 out_free;
    logic                 emit;
    t_out_item            res;

    assign in_data = i_item.data;

    tsat_slot_table #(
        .ALARM_SLOTS(ALARM_SLOTS),
        .TAG_WIDTH  (TAG_WIDTH),
        .IDX_W      (IDX_W)
    ) u_slot_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (slot_ctrl),
        .i_idx    (r_idx),
        .i_wr_time(r_set_time),
        .i_wr_tag (r_tag),
        .o_valid  (rd_valid),
        .o_time   (rd_time),
        .o_tag    (rd_tag)
    );

    assign alarm_time.hours   = {3'b000, rd_time.hours};
    assign alarm_time.minutes = {2'b00, rd_time.minutes};
    assign alarm_time.seconds = {2'b00, rd_time.seconds};

    tsat_time_cmp u_time_cmp (
        .i_lhs (alarm_time),
        .i_rhs (r_now),
        .o_less(alarm_early)
    );

    assign out_free       = !r_o_valid || o_result.ready;
    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_o_valid;
    assign o_result.data  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_bad      <= n_bad;
        r_set_time <= n_set_time;
        r_tag      <= n_tag;
        r_now      <= n_now;
        r_pending  <= n_pending;
        r_o_data   <= n_o_data;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_bad      = r_bad;
        n_set_time = r_set_time;
        n_tag      = r_tag;
        n_now      = r_now;
        n_pending  = r_pending;
        n_o_valid  = r_o_valid && !o_result.ready;
        n_o_data   = r_o_data;
        slot_ctrl  = '0;
        emit       = 1'b0;
        res        = t_out_item'('0);

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_bad = (in_data.alarm_hours > MAX_HOURS)
                         || (in_data.alarm_minutes > MAX_MINSEC)
                         || (in_data.alarm_seconds > MAX_MINSEC);
                    n_set_time.hours   = in_data.alarm_hours[4:0];
                    n_set_time.minutes = in_data.alarm_minutes[5:0];
                    n_set_time.seconds = in_data.alarm_seconds[5:0];
                    n_tag              = TAG_WIDTH'(in_data.alarm_tag);
                    n_now.hours        = bcd_to_bin(in_data.now_hours_bcd);
                    n_now.minutes      = bcd_to_bin(in_data.now_minutes_bcd);
                    n_now.seconds      = bcd_to_bin(in_data.now_seconds_bcd);
                    n_idx              = '0;
                    n_pending          = '0;
                    n_state = (in_data.kind == KIND_SET) ? S_SET : S_CHECK;
                end
            end
            S_SET: begin
                if (out_free) begin
                    res.result_kind = RES_SET;
                    res.last        = 1'b1;
                    if (r_bad) begin
                        emit           = 1'b1;
                        res.set_status = ST_RANGE;
                        n_state        = S_IDLE;
                    end else if (!rd_valid) begin
                        emit           = 1'b1;
                        slot_ctrl.wr   = 1'b1;
                        res.set_status = ST_STORED;
                        res.slot_index = 2'(r_idx);
                        n_state        = S_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        emit           = 1'b1;
                        res.set_status = ST_FULL;
                        n_state        = S_IDLE;
                    end else begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    if (rd_valid && alarm_early) begin
                        emit            = 1'b1;
                        slot_ctrl.clr   = 1'b1;
                        res.result_kind = RES_FIRED;
                        res.slot_index  = 2'(r_idx);
                        res.fired_tag   = 8'(rd_tag);
                    end else if (rd_valid) begin
                        n_pending = CNT_W'(r_pending + 1'b1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_SUM;
                    end else begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    emit              = 1'b1;
                    res.result_kind   = RES_SUMMARY;
                    res.pending_count = 2'(r_pending);
                    res.keep_running  = (r_pending != '0);
                    res.last          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_o_valid = 1'b1;
            n_o_data  = res;
        end
    end
endmodule

// File: rtl/tsat_checker.sv
`include "three_slot_time_alarm_table_assert.svh"

module tsat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tsat_pkg::t_out_item i_out_data
);
    import tsat_pkg::*;

    // Once an item is taken, the block is busy for at least the next cycle.
    `TSAT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    `TSAT_ASSERT_NEXT(a_result_held, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // Only a fired alarm is followed by further results of the same item.
    `TSAT_ASSERT_SAME(a_last_marking, i_out_valid, i_out_data.last == (i_out_data.result_kind != RES_FIRED))

    `TSAT_ASSERT_SAME(a_keep_running, i_out_valid && (i_out_data.pending_count != 2'd0), i_out_data.keep_running)
endmodule

bind three_slot_time_alarm_table tsat_checker u_tsat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_data (o_result.data)
);
